// ----- rtl/core/cgds_pkg.sv -----
// ----------------------------------------------------------------------------
// Clock generator divider select package
// Shared widths, constants, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cgds_pkg;

	localparam int HZ_W          = 27;
	localparam int CH_W          = 4;
	localparam int LEAD_W        = 5;
	localparam int FIELD_W       = 16;
	localparam int IN_DATA_W     = 32;
	localparam int OUT_DATA_W    = 96;
	localparam int NUM_CHANNELS_DEF = 9;

	localparam logic [HZ_W-1:0] REF_RESET = 27'd48000000;
	localparam logic [2:0]      SRC_SEL   = 3'h7;

	// Channel numbers with their own divider widths.
	localparam logic [CH_W-1:0] CH_WIDE   = 4'd1;
	localparam logic [CH_W-1:0] CH_NARROW = 4'd2;

	// Request kinds carried on the input tuser.
	localparam logic ACT_SET   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV1,
		ST_PICK,
		ST_DIV2,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;    // latch the request
		logic div_start;  // start the iterative divider
		logic div_sel;    // 0: reference / wanted, 1: reference / first quotient
		logic pick;       // latch the divider mode and field
		logic emit;       // load the output register and update the table
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic is_query;
		logic is_error;
		logic fits_direct;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/cgds_div.sv -----
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle, MSB first. Also
// records the position of the quotient's leading one as it is produced.
// ----------------------------------------------------------------------------
module cgds_div
	import cgds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HZ_W-1:0]   dividend,
	input  logic [HZ_W-1:0]   divisor,
	output logic              done,
	output logic [HZ_W-1:0]   quotient,
	output logic [LEAD_W-1:0] lead
);

	logic              busy_q;
	logic              done_q;
	logic              found_q;
	logic [LEAD_W-1:0] cnt_q;
	logic [LEAD_W-1:0] lead_q;
	logic [HZ_W-1:0]   dvd_q;
	logic [HZ_W-1:0]   dvs_q;
	logic [HZ_W-1:0]   rem_q;
	logic [HZ_W:0]     trial;
	logic              qbit;

	assign trial = {rem_q, dvd_q[HZ_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				found_q <= 1'b0;
				cnt_q   <= LEAD_W'(HZ_W - 1);
			end else if (busy_q) begin
				if (qbit)
					found_q <= 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The quotient bits shift into the dividend register as its bits move out.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			lead_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? HZ_W'(trial - {1'b0, dvs_q}) : trial[HZ_W-1:0];
			dvd_q <= {dvd_q[HZ_W-2:0], qbit};
			if (qbit && !found_q)
				lead_q <= cnt_q;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
	assign lead     = lead_q;

endmodule

// ----- rtl/core/cgds_dp.sv -----
// ----------------------------------------------------------------------------
// Divider select datapath
// Request and reference registers, the iterative divider, the per-channel
// frequency table and the output register.
// ----------------------------------------------------------------------------
module cgds_dp
	import cgds_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [HZ_W-1:0]       cfg_wr_data,
	input  logic                  s_tvalid,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int IDX_W = $clog2(NUM_CHANNELS);
	localparam logic [CH_W:0] CH_LIMIT = (CH_W+1)'(NUM_CHANNELS);

	logic [HZ_W-1:0]    ref_q;
	logic               action_q;
	logic [CH_W-1:0]    ch_q;
	logic [HZ_W-1:0]    wanted_q;
	logic               pow2_q;
	logic [FIELD_W-1:0] field_q;
	logic [HZ_W-1:0]    shact_q;
	logic [HZ_W-1:0]    table_q [NUM_CHANNELS];

	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic               out_status_q;

	logic [HZ_W-1:0]    quo;
	logic [LEAD_W-1:0]  lead;
	logic               div_done;
	logic               in_range;
	logic [IDX_W-1:0]   idx;
	logic               fits;
	logic               is_err;
	logic [HZ_W-1:0]    actual;
	logic [31:0]        div_word;
	logic [31:0]        ctl_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ref_q <= REF_RESET;
		else if (cfg_wr_en)
			ref_q <= cfg_wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= s_tuser;
			ch_q     <= s_tdata[CH_W-1:0];
			wanted_q <= s_tdata[CH_W +: HZ_W];
		end
	end

	cgds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (ref_q),
		.divisor  (cmd.div_sel ? quo : wanted_q),
		.done     (div_done),
		.quotient (quo),
		.lead     (lead)
	);

	assign in_range = ({1'b0, ch_q} < CH_LIMIT);
	assign idx      = ch_q[IDX_W-1:0];
	assign is_err   = (wanted_q == '0) || (wanted_q > ref_q);

	always_comb begin
		if (ch_q == CH_WIDE)
			fits = (quo[HZ_W-1:16] == '0);
		else if (ch_q == CH_NARROW)
			fits = (quo[HZ_W-1:5] == '0);
		else
			fits = (quo[HZ_W-1:8] == '0);
	end

	// In power-of-two mode the field is the leading-one position minus one;
	// it stays below the narrowest channel limit for any 27-bit quotient.
	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			pow2_q  <= !fits;
			field_q <= fits ? quo[FIELD_W-1:0] : FIELD_W'(lead) - 1'b1;
			shact_q <= ref_q >> lead;
		end
	end

	always_comb begin
		actual   = '0;
		div_word = '0;
		ctl_word = '0;
		if (action_q == ACT_QUERY) begin
			actual = in_range ? table_q[idx] : '0;
		end else if (!is_err) begin
			actual   = pow2_q ? shact_q : quo;
			div_word = {8'h00, field_q, 4'h0, ch_q};
			ctl_word = {11'h000, pow2_q, 2'b00, 1'b1, 1'b1, 5'h00, SRC_SEL, 4'h0, ch_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CHANNELS; k++)
				table_q[k] <= '0;
		end else if (cmd.emit && action_q == ACT_SET && !is_err && in_range) begin
			table_q[idx] <= actual;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= (action_q == ACT_SET) && is_err;
			out_data_q   <= {5'h00, ctl_word, div_word, actual};
		end
	end

	assign sts.in_valid    = s_tvalid;
	assign sts.is_query    = (action_q == ACT_QUERY);
	assign sts.is_error    = is_err;
	assign sts.fits_direct = fits;
	assign sts.div_done    = div_done;
	assign sts.out_free    = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

endmodule

// ----- rtl/core/cgds_ctrl.sv -----
// ----------------------------------------------------------------------------
// Divider select controller
// Sequences one request: capture, range check, first division, mode pick,
// optional second division and hand-off to the output register.
// ----------------------------------------------------------------------------
module cgds_ctrl
	import cgds_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd,
	output logic s_tready
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid)
					state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.is_query || sts.is_error)
					state_nxt = ST_EMIT;
				else
					state_nxt = ST_DIV1;
			end
			ST_DIV1: begin
				if (sts.div_done)
					state_nxt = ST_PICK;
			end
			ST_PICK: begin
				if (sts.fits_direct)
					state_nxt = ST_DIV2;
				else
					state_nxt = ST_EMIT;
			end
			ST_DIV2: begin
				if (sts.div_done)
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = sts.in_valid;
			end
			ST_CHECK: begin
				cmd.div_start = !(sts.is_query || sts.is_error);
			end
			ST_PICK: begin
				cmd.pick      = 1'b1;
				cmd.div_sel   = 1'b1;
				cmd.div_start = sts.fits_direct;
			end
			ST_DIV2: begin
				cmd.div_sel = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- rtl/core/clock_generator_divider_select_core.sv -----
// A query or a rejected set goes from the range check to the output register;
// a power-of-two set runs one division first and a direct set runs two.
// One request at a time: no new request is taken until the last one reaches
// the output register. The single 27-step iterative divider serves both divisions.
// A finished result waits in the output register while the next one is taken.
// Reset (arst_n, asynchronous): reference 48 MHz, table cleared, no result.
// ----------------------------------------------------------------------------
// Clock generator divider select core
// Picks a direct or power-of-two divider for a generator channel and keeps
// the achieved frequency of each channel for queries.
// ----------------------------------------------------------------------------
module clock_generator_divider_select_core
	import cgds_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [HZ_W-1:0]       cfg_wr_data,   // reference_hz
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,       // channel, wanted_hz
	input  logic                  s_tuser,       // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,       // actual_hz, divider_word, control_word
	output logic                  m_tuser        // status
);

	cmd_t cmd;
	sts_t sts;

	cgds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	cgds_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ----- rtl/core/cgds_checker.sv -----
// ----------------------------------------------------------------------------
// Divider select port checker
// Watches the top-level ports for output stability and result consistency.
// ----------------------------------------------------------------------------
module cgds_checker
	import cgds_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A rejected request carries nothing but its status.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("rejected request carries data");

	// Both words of a successful set name the same channel.
	a_same_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[90:59] != '0 |-> m_tdata[34:27] == m_tdata[66:59])
		else $error("channel differs between words");

	// A control word always enables the generator with the fixed source.
	a_ctl_bits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[90:59] != '0 |->
			m_tdata[75] && m_tdata[76] && m_tdata[69:67] == SRC_SEL)
		else $error("control word malformed");

	// An accepted request cannot produce a result in the very next cycle.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind clock_generator_divider_select_core cgds_checker u_cgds_checker (.*);

// ----- tb/clock_generator_divider_select_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clock generator divider select core test
// Sends set and query requests over the input stream and checks every result
// on the output stream against a behavioral divider selector. The reference
// frequency is changed between phases while the block is idle. Both stream
// sides idle at random, except in one phase without idling.
// ----------------------------------------------------------------------------
module clock_generator_divider_select_core_test;

	import cgds_pkg::*;

	localparam logic        STATUS_OK      = 1'b0;
	localparam logic        STATUS_UNREACH = 1'b1;
	localparam logic [31:0] ENABLE_BIT     = 32'h0001_0000;
	localparam logic [31:0] DUTY_BIT       = 32'h0002_0000;
	localparam logic [31:0] DIVSEL_BIT     = 32'h0010_0000;
	localparam int          WIDE_BITS      = 16;
	localparam int          NARROW_BITS    = 5;
	localparam int          BASE_BITS      = 8;
	localparam int unsigned HZ_MAX         = (1 << HZ_W) - 1;
	localparam int unsigned REF_TOP        = 100000000;
	localparam int          IDLE_PCT       = 22;
	localparam int          STALL_LIMIT    = 2000;
	localparam int          DRAIN_CYCLES   = 70;
	localparam int          PHASES         = 6;
	localparam int          PHASE_ITEMS    = 158;
	localparam int          QUIET_PHASE    = 3;

	typedef struct packed {
		logic            action;
		logic [CH_W-1:0] channel;
		logic [HZ_W-1:0] wanted_hz;
	} req_t;

	typedef struct packed {
		logic            status;
		logic [HZ_W-1:0] actual_hz;
		logic [31:0]     divider_word;
		logic [31:0]     control_word;
	} result_t;

	typedef struct {
		req_t    req;
		bit      typed;
		result_t res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [HZ_W-1:0]       cfg_wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	logic [HZ_W-1:0] osc_hz;
	logic [31:0]     chan_hz [NUM_CHANNELS_DEF];
	result_t         divider_results_q [$];
	dir_row_t        dir_rows [$];
	bit              quiet = 1'b0;
	int              fault_count = 0;
	int              stall_count = 0;
	result_t         got_res;
	result_t         want_res;

	clock_generator_divider_select_core #(
		.NUM_CHANNELS(NUM_CHANNELS_DEF)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	always #5 clk = ~clk;

	// Expected outcome of one request; a successful set on a channel within the table also updates the channel table.
	function automatic result_t select_divider(input req_t rq);
		result_t     r;
		logic [31:0] ref32;
		logic [31:0] quot;
		logic [31:0] lim;
		logic [31:0] field;
		logic [31:0] achieved;
		logic [31:0] sel;
		int          lead;
		int          w;
		r = '0;
		ref32 = 32'(osc_hz);
		if (rq.action == ACT_QUERY) begin
			if (rq.channel < NUM_CHANNELS_DEF)
				r.actual_hz = chan_hz[rq.channel][HZ_W-1:0];
			return r;
		end
		if (rq.wanted_hz == '0 || 32'(rq.wanted_hz) > ref32) begin
			r.status = STATUS_UNREACH;
			return r;
		end
		quot = ref32 / 32'(rq.wanted_hz);
		w = (rq.channel == CH_WIDE) ? WIDE_BITS :
			(rq.channel == CH_NARROW) ? NARROW_BITS : BASE_BITS;
		lim = (32'd1 << w) - 32'd1;
		sel = '0;
		if (quot <= lim) begin
			field = quot;
			achieved = ref32 / quot;
		end else begin
			lead = 0;
			for (int b = 0; b < 32; b++)
				if (quot[b])
					lead = b;
			if (lead == 0 || 32'(lead - 1) > lim) begin
				r.status = STATUS_UNREACH;
				return r;
			end
			field = 32'(lead - 1);
			achieved = ref32 >> lead;
			sel = DIVSEL_BIT;
		end
		if (rq.channel < NUM_CHANNELS_DEF)
			chan_hz[rq.channel] = achieved;
		r.status = STATUS_OK;
		r.actual_hz = achieved[HZ_W-1:0];
		r.divider_word = 32'(rq.channel) | (field << 8);
		r.control_word = 32'(rq.channel) | (32'(SRC_SEL) << 8) | ENABLE_BIT | DUTY_BIT | sel;
		return r;
	endfunction

	// Wanted frequencies spread over errors, exact hits, divider width edges and
	// the whole range below the current reference.
	function automatic logic [HZ_W-1:0] draw_wanted_hz(input logic [HZ_W-1:0] ref_hz);
		int unsigned pick;
		int unsigned span;
		int unsigned v;
		int          w;
		pick = $urandom_range(99, 0);
		span = 32'(ref_hz);
		if (pick < 4) begin
			v = 0;
		end else if (pick < 10) begin
			v = (span >= HZ_MAX) ? $urandom_range(HZ_MAX, 0) : $urandom_range(HZ_MAX, span + 1);
		end else if (pick < 14) begin
			v = $urandom_range(HZ_MAX, 0);
		end else if (pick < 20) begin
			v = span;
		end else if (pick < 45) begin
			v = $urandom_range(span, 1);
		end else if (pick < 65) begin
			v = $urandom_range((span < 2000) ? span : 2000, 1);
		end else if (pick < 85) begin
			case ($urandom_range(2, 0))
				0: w = NARROW_BITS;
				1: w = BASE_BITS;
				default: w = WIDE_BITS;
			endcase
			v = span / ((1 << w) - 1 + $urandom_range(1, 0));
			if (v == 0)
				v = 1;
			v = v + $urandom_range(1, 0);
		end else begin
			v = span >> $urandom_range(HZ_W - 1, 0);
			if (v == 0)
				v = 1;
		end
		return v[HZ_W-1:0];
	endfunction

	task automatic add_row(input logic act, input int unsigned ch, input int unsigned hz,
			input bit typed, input logic st, input int unsigned actual,
			input logic [31:0] dw, input logic [31:0] cw);
		dir_row_t row;
		row.req = '{action: act, channel: ch[CH_W-1:0], wanted_hz: hz[HZ_W-1:0]};
		row.typed = typed;
		row.res = '{status: st, actual_hz: actual[HZ_W-1:0], divider_word: dw,
			control_word: cw};
		dir_rows.push_back(row);
	endtask

	// Typed rows carry their own expectation but still go through the
	// predictor so the channel table stays in step.
	task automatic send_req(input req_t rq, input bit typed, input result_t typed_res);
		result_t pred;
		while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq.action;
		s_tdata <= {1'b0, rq.wanted_hz, rq.channel};
		do
			@(posedge clk);
		while (!s_tready);
		pred = select_divider(rq);
		divider_results_q.push_back(typed ? typed_res : pred);
	endtask

	task automatic await_results();
		s_tvalid <= 1'b0;
		while (divider_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reference(input logic [HZ_W-1:0] hz);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hz;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		osc_hz = hz;
	endtask

	// Result side: random stalls and the scoreboard check.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_res.status = m_tuser;
				got_res.actual_hz = m_tdata[HZ_W-1:0];
				got_res.divider_word = m_tdata[HZ_W+31:HZ_W];
				got_res.control_word = m_tdata[HZ_W+63:HZ_W+32];
				if (divider_results_q.size() == 0) begin
					fault_count++;
					$display("%0t: unexpected result status %0d actual %0d div %h ctrl %h",
						$time, got_res.status, got_res.actual_hz,
						got_res.divider_word, got_res.control_word);
				end else begin
					want_res = divider_results_q.pop_front();
					if (got_res.status !== want_res.status ||
							got_res.actual_hz !== want_res.actual_hz ||
							got_res.divider_word !== want_res.divider_word ||
							got_res.control_word !== want_res.control_word) begin
						fault_count++;
						$display("%0t: expected status %0d actual %0d div %h ctrl %h, got status %0d actual %0d div %h ctrl %h",
							$time, want_res.status, want_res.actual_hz,
							want_res.divider_word, want_res.control_word,
							got_res.status, got_res.actual_hz,
							got_res.divider_word, got_res.control_word);
					end
				end
			end
			m_tready <= quiet || ($urandom_range(99, 0) >= IDLE_PCT);
		end
	end

	// Watchdog on cycles in which no transaction completes on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		req_t            rq;
		logic [HZ_W-1:0] hz;
		osc_hz = REF_RESET;
		for (int c = 0; c < NUM_CHANNELS_DEF; c++)
			chan_hz[c] = '0;

		// Reset state, unreachable requests and easy direct dividers.
		add_row(ACT_QUERY, 0, 0, 1'b1, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_QUERY, 8, 5, 1'b1, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_QUERY, 15, HZ_MAX, 1'b1, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 0, 0, 1'b1, STATUS_UNREACH, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 3, 48000001, 1'b1, STATUS_UNREACH, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 1, HZ_MAX, 1'b1, STATUS_UNREACH, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 7, REF_TOP, 1'b1, STATUS_UNREACH, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 0, 48000000, 1'b1, STATUS_OK, 48000000, 32'h0000_0100, 32'h0003_0700);
		add_row(ACT_SET, 5, 24000000, 1'b1, STATUS_OK, 24000000, 32'h0000_0205, 32'h0003_0705);
		// Width edges, power-of-two mode, and channels beyond the table.
		add_row(ACT_SET, 1, 1, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 2, 1500000, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 2, 1548388, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 3, 187500, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 4, 188236, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 1, 733, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 8, 1000, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 9, 1000, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 15, 24000000, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_SET, 6, 47999999, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_QUERY, 1, 0, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_QUERY, 2, 0, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_QUERY, 8, 0, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_QUERY, 9, 0, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);
		add_row(ACT_QUERY, 5, 0, 1'b0, STATUS_OK, 0, 32'h0, 32'h0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < dir_rows.size(); k++)
			send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);

		for (int p = 0; p < PHASES; p++) begin
			await_results();
			case (p)
				0: hz = HZ_W'(REF_TOP);
				1: hz = HZ_W'(1);
				3: hz = HZ_W'(32768);
				5: hz = REF_RESET;
				default: hz = HZ_W'($urandom_range(REF_TOP, 1));
			endcase
			write_reference(hz);
			quiet = (p == QUIET_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				rq.action = ($urandom_range(99, 0) < 25) ? ACT_QUERY : ACT_SET;
				rq.channel = ($urandom_range(99, 0) < 85)
					? CH_W'($urandom_range(NUM_CHANNELS_DEF - 1, 0))
					: CH_W'($urandom_range(15, NUM_CHANNELS_DEF));
				rq.wanted_hz = draw_wanted_hz(osc_hz);
				send_req(rq, 1'b0, '0);
			end
		end

		await_results();
		quiet = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
